/* src/pusi_pkg.sv */
package pusi_pkg;
    localparam int FRAC_BITS = 16;
    // Unit vector magnitude never exceeds 2^16, so eighteen quotient bits leave headroom.
    localparam int UNIT_BITS = 18;
    localparam int UNIT_CNT_BITS = 5;
    localparam int SQRT_EXTRA = 18;
endpackage

/* src/pusi_front.sv */
module pusi_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COORD_BITS-1:0] s_checkpoint_x,
    input  logic signed [COORD_BITS-1:0] s_checkpoint_y,
    input  logic                        s_start_path,
    output logic                        push_valid,
    input  logic                        push_ready,
    output logic [4*COORD_BITS+1:0]     push_data
);
    import pusi_pkg::*;

    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic                         have_prev_reg;
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic                         accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;
    assign dx = (COORD_BITS+1)'(s_checkpoint_x) - (COORD_BITS+1)'(prev_x_reg);
    assign dy = (COORD_BITS+1)'(s_checkpoint_y) - (COORD_BITS+1)'(prev_y_reg);

    // Only segments go to the back end; a path start just updates the held point.
    assign push_valid = s_valid && !s_start_path && have_prev_reg;
    assign push_data  = {prev_x_reg, prev_y_reg, dx, dy};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
        end else if (accept) begin
            prev_x_reg    <= s_checkpoint_x;
            prev_y_reg    <= s_checkpoint_y;
            have_prev_reg <= 1'b1;
        end
    end
endmodule

/* src/pusi_queue.sv */
module pusi_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    import pusi_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

/* src/pusi_back.sv */
module pusi_back #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  logic [4*COORD_BITS+1:0]      job_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_point_x,
    output logic signed [COORD_BITS-1:0] m_point_y,
    output logic                         m_last_point,
    output logic                         m_truncated
);
    import pusi_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int PAIRS  = C + SQRT_EXTRA;
    localparam int SW     = 2*C + 3;
    localparam int NUMW   = C + 33;
    localparam int DW     = PAIRS + 1;
    localparam int AW     = C + 24;
    localparam int NW     = C + 2;
    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int PCW    = $clog2(PAIRS);

    typedef enum logic [2:0] {S_IDLE, S_SQUARE, S_SQRT, S_DIV, S_EMIT} state_t;

    state_t                   state_reg;
    logic signed [C-1:0]      px_reg, py_reg;
    logic signed [C:0]        dx_reg, dy_reg;
    logic [SW-1:0]            s_val;
    logic [2*PAIRS-1:0]       s_sh_reg;
    logic [PAIRS-1:0]         root_reg;
    logic [PAIRS+1:0]         rem_reg;
    logic [PCW-1:0]           pcnt_reg;
    logic [UNIT_CNT_BITS-1:0] dcnt_reg;
    logic [DW-1:0]            remx_reg, remy_reg;
    logic [UNIT_BITS-1:0]     numx_reg, numy_reg;
    logic [UNIT_BITS-1:0]     qx_reg, qy_reg;
    logic signed [AW-1:0]     accx_reg, accy_reg;
    logic signed [AW-1:0]     ux_reg, uy_reg;
    logic [CW-1:0]            cnt_reg, k_reg;
    logic                     trunc_reg;
    logic [C:0]               adx, ady;
    logic [PAIRS+1:0]         rem_try, trial;
    logic [PAIRS-1:0]         lq;
    logic [NW-1:0]            n_val;
    logic                     n_over;
    logic [NUMW-1:0]          nx, ny;
    logic [DW-1:0]            tx, ty;
    logic                     out_free;
    logic [C-1:0]             rx, ry;
    logic [UNIT_BITS:0]       qx_fin, qy_fin;

    function automatic logic [C-1:0] round_sat(input logic signed [AW-1:0] v);
        logic [AW-1:0]    m;
        logic [AW-16:0]   r;
        logic [C-1:0]     res;
        m = v[AW-1] ? AW'(-v) : AW'(v);
        r = (AW-15)'(({1'b0, m} + (AW+1)'(32'h8000)) >> FRAC_BITS);
        if (!v[AW-1]) begin
            if (r > (AW-15)'((1 << (C-1)) - 1)) res = {1'b0, {(C-1){1'b1}}};
            else                                res = r[C-1:0];
        end else begin
            if (r > (AW-15)'(1 << (C-1))) res = {1'b1, {(C-1){1'b0}}};
            else                          res = C'(-r[C-1:0]);
        end
        return res;
    endfunction

    assign adx = dx_reg[C] ? (C+1)'(-dx_reg) : dx_reg;
    assign ady = dy_reg[C] ? (C+1)'(-dy_reg) : dy_reg;
    assign s_val = SW'(adx * adx) + SW'(ady * ady);

    // One root bit per cycle; bit pairs of s * 2^32 come off the top of the shifter.
    assign rem_try = {rem_reg[PAIRS-1:0], s_sh_reg[2*PAIRS-1 -: 2]};
    assign trial   = {root_reg, 2'b01};

    assign lq     = root_reg;
    assign n_val  = NW'((lq - PAIRS'(1)) >> FRAC_BITS);
    assign n_over = n_val > NW'(MAX_POINTS);
    assign nx     = {adx, 32'b0} + NUMW'(lq >> 1);
    assign ny     = {ady, 32'b0} + NUMW'(lq >> 1);

    assign tx = {remx_reg[DW-2:0], numx_reg[UNIT_BITS-1]};
    assign ty = {remy_reg[DW-2:0], numy_reg[UNIT_BITS-1]};
    assign qx_fin = {1'b0, qx_reg[UNIT_BITS-2:0], tx >= DW'(lq)};
    assign qy_fin = {1'b0, qy_reg[UNIT_BITS-2:0], ty >= DW'(lq)};

    assign out_free  = !m_valid || m_ready;
    assign job_ready = (state_reg == S_IDLE);
    assign rx = round_sat(accx_reg);
    assign ry = round_sat(accy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid   <= 1'b0;
        end else begin
            if (m_valid && m_ready && state_reg != S_EMIT) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        {px_reg, py_reg, dx_reg, dy_reg} <= job_data;
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    s_sh_reg  <= (2*PAIRS)'(s_val) << 32;
                    root_reg  <= '0;
                    rem_reg   <= '0;
                    pcnt_reg  <= PCW'(PAIRS - 1);
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    s_sh_reg <= s_sh_reg << 2;
                    if (rem_try >= trial) begin
                        rem_reg  <= rem_try - trial;
                        root_reg <= {root_reg[PAIRS-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_try;
                        root_reg <= {root_reg[PAIRS-2:0], 1'b0};
                    end
                    pcnt_reg <= pcnt_reg - PCW'(1);
                    if (pcnt_reg == '0) begin
                        dcnt_reg  <= UNIT_CNT_BITS'(UNIT_BITS);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Root known: drop short segment, else set-up and two unit divisions.
                    if (dcnt_reg == UNIT_CNT_BITS'(UNIT_BITS)) begin
                        if (lq <= PAIRS'(1 << FRAC_BITS)) begin
                            state_reg <= S_IDLE;
                        end else begin
                            trunc_reg <= n_over;
                            cnt_reg   <= n_over ? CW'(MAX_POINTS) : CW'(n_val);
                            remx_reg  <= DW'(nx >> UNIT_BITS);
                            remy_reg  <= DW'(ny >> UNIT_BITS);
                            numx_reg  <= nx[UNIT_BITS-1:0];
                            numy_reg  <= ny[UNIT_BITS-1:0];
                            qx_reg    <= '0;
                            qy_reg    <= '0;
                            dcnt_reg  <= UNIT_CNT_BITS'(UNIT_BITS - 1);
                        end
                    end else begin
                        remx_reg <= (tx >= DW'(lq)) ? tx - DW'(lq) : tx;
                        remy_reg <= (ty >= DW'(lq)) ? ty - DW'(lq) : ty;
                        numx_reg <= numx_reg << 1;
                        numy_reg <= numy_reg << 1;
                        qx_reg   <= qx_fin[UNIT_BITS-1:0];
                        qy_reg   <= qy_fin[UNIT_BITS-1:0];
                        dcnt_reg <= dcnt_reg - UNIT_CNT_BITS'(1);
                        if (dcnt_reg == '0) begin
                            ux_reg    <= dx_reg[C] ? -AW'(qx_fin) : AW'(qx_fin);
                            uy_reg    <= dy_reg[C] ? -AW'(qy_fin) : AW'(qy_fin);
                            accx_reg  <= (AW'(px_reg) <<< FRAC_BITS)
                                         + (dx_reg[C] ? -AW'(qx_fin) : AW'(qx_fin));
                            accy_reg  <= (AW'(py_reg) <<< FRAC_BITS)
                                         + (dy_reg[C] ? -AW'(qy_fin) : AW'(qy_fin));
                            k_reg     <= '0;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid      <= 1'b1;
                        m_point_x    <= rx;
                        m_point_y    <= ry;
                        m_last_point <= (k_reg == cnt_reg - CW'(1));
                        m_truncated  <= (k_reg == cnt_reg - CW'(1)) && trunc_reg;
                        accx_reg     <= accx_reg + ux_reg;
                        accy_reg     <= accy_reg + uy_reg;
                        k_reg        <= k_reg + CW'(1);
                        if (k_reg == cnt_reg - CW'(1)) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_trunc_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> m_last_point)
        else $error("truncated flag without last point");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> k_reg < cnt_reg)
        else $error("point index ran past segment count");
    a_no_job_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !job_ready)
        else $error("job taken while a segment is in progress");
endmodule

/* src/polyline_unit_step_interpolator.sv */
// Path: each segment passes the queue, job capture, squaring, root, divide and
// output register before its first point is presented; the back end takes a new segment
// only when idle, emits up to MAX_POINTS points per segment and none for a segment too
// short to emit; checkpoints are taken while the two-entry queue has room.
// Reset: synchronous, active low; clears the held checkpoint, queue and sequencer.
module polyline_unit_step_interpolator #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_checkpoint_x,
    input  logic signed [COORD_BITS-1:0] s_checkpoint_y,
    input  logic                         s_start_path,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_point_x,
    output logic signed [COORD_BITS-1:0] m_point_y,
    output logic                         m_last_point,
    output logic                         m_truncated
);
    import pusi_pkg::*;

    localparam int JW = 4*COORD_BITS + 2;

    logic          push_valid, push_ready;
    logic [JW-1:0] push_data;
    logic          job_valid, job_ready;
    logic [JW-1:0] job_data;

    pusi_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_checkpoint_x(s_checkpoint_x), .s_checkpoint_y(s_checkpoint_y),
        .s_start_path(s_start_path),
        .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
    );

    pusi_queue #(.WIDTH(JW)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(push_valid), .wr_ready(push_ready), .wr_data(push_data),
        .rd_valid(job_valid), .rd_ready(job_ready), .rd_data(job_data)
    );

    pusi_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job_data(job_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_point_x(m_point_x), .m_point_y(m_point_y),
        .m_last_point(m_last_point), .m_truncated(m_truncated)
    );
endmodule
